// ----- hdl/mbps_pkg.sv -----
// Shared constants, codes and types of the masked byte pattern scanner.
// No dependencies; every other file of the block except mbps_ram imports this package.
package mbps_pkg;

	// Pattern storage and derived widths
	localparam int PATTERN_MAX = 256;
	localparam int PAT_AW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

	// Match reduction: cells are folded in registered groups
	localparam int GRP_SIZE = 16;
	localparam int GRP_NUM  = (PATTERN_MAX + GRP_SIZE - 1) / GRP_SIZE;
	localparam int PAD_N    = GRP_NUM * GRP_SIZE;

	// Field widths
	localparam int ACT_W     = 2;
	localparam int IDX_W     = 8;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 64;
	localparam int CNT_W     = 16;
	localparam int LEN_CFG_W = 9;
	localparam int STEP_W    = 16;

	// Configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 64;
	localparam int REG_LSB = 3;

	// Register reset values
	localparam logic [LEN_CFG_W-1:0] LEN_RST   = LEN_CFG_W'(1);
	localparam logic [STEP_W-1:0]    STEP_RST  = STEP_W'(1);
	localparam logic [CNT_W-1:0]     LIMIT_RST = CNT_W'(1024);
	localparam logic [ADDR_W-1:0]    BASE_RST  = '0;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_SCAN  = 2'd2,
		ACT_RSVD  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_LEN   = 2'd0,
		REG_STEP  = 2'd1,
		REG_LIMIT = 2'd2,
		REG_BASE  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REBUILD,
		ST_CMP,
		ST_RED,
		ST_DEC
	} state_t;

	typedef struct packed {
		logic [LEN_CFG_W-1:0] len;
		logic [STEP_W-1:0]    step;
		logic [CNT_W-1:0]     limit;
		logic [ADDR_W-1:0]    base;
	} cfg_t;

	// Controls broadcast to every cell of the row
	typedef struct packed {
		logic win_shift;
		logic pat_shift;
		logic clear;
	} cell_ctl_t;

	// One aligned pattern position as it travels down the row
	typedef struct packed {
		logic [BYTE_W-1:0] val;
		logic              care;
		logic              anchor;
	} pat_ent_t;

endpackage

// ----- hdl/mbps_req_if.sv -----
// Request channel of the scanner: valid/ready handshake plus request fields.
// Depends on mbps_pkg for field widths.
interface mbps_req_if import mbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [IDX_W-1:0]  entry_index;
	logic [BYTE_W-1:0] entry_byte;
	logic              entry_cares;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, action, entry_index, entry_byte, entry_cares, data_byte,
		input ready);
	modport sink (input valid, action, entry_index, entry_byte, entry_cares, data_byte,
		output ready);
endinterface

// ----- hdl/mbps_hit_if.sv -----
// Hit channel of the scanner: valid/ready handshake plus hit report fields.
// Depends on mbps_pkg for field widths.
interface mbps_hit_if import mbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] hit_address;
	logic [CNT_W-1:0]  hit_number;
	logic              limit_reached;

	modport source (output valid, hit_address, hit_number, limit_reached, input ready);
	modport sink (input valid, hit_address, hit_number, limit_reached, output ready);
endinterface

// ----- hdl/mbps_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hdl/mbps_cell.sv -----
// One cell of the scanner row: a window byte and an aligned pattern position.
// Depends on mbps_pkg; chained by mbps_row.
module mbps_cell import mbps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [BYTE_W-1:0] win_in,
	input  pat_ent_t          pat_in,
	output logic [BYTE_W-1:0] win_out,
	output pat_ent_t          pat_out,
	output logic              match_s1,
	output logic              anchor_s1
);
	logic [BYTE_W-1:0] win_q;
	logic [BYTE_W-1:0] val_q;
	logic              care_q;
	logic              anchor_q;
	logic              eq;

	// Window byte and care/anchor flags: shift from the neighbor, drop on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			care_q   <= 1'b0;
			anchor_q <= 1'b0;
		end else if (ctl.clear) begin
			win_q    <= '0;
			care_q   <= 1'b0;
			anchor_q <= 1'b0;
		end else begin
			if (ctl.win_shift) begin
				win_q <= win_in;
			end
			if (ctl.pat_shift) begin
				care_q   <= pat_in.care;
				anchor_q <= pat_in.anchor;
			end
		end
	end

	// Pattern byte; only read where its care flag is set
	always_ff @(posedge clk) begin
		if (ctl.pat_shift) begin
			val_q <= pat_in.val;
		end
	end

	assign eq = (val_q == win_q);

	// Register the local compare
	always_ff @(posedge clk) begin
		match_s1  <= !care_q || eq;
		anchor_s1 <= anchor_q && eq;
	end

	assign win_out        = win_q;
	assign pat_out.val    = val_q;
	assign pat_out.care   = care_q;
	assign pat_out.anchor = anchor_q;
endmodule

// ----- hdl/mbps_row.sv -----
// Row of scanner cells, ordered by byte age, with registered group reduction.
// Depends on mbps_pkg and mbps_cell.
module mbps_row import mbps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [BYTE_W-1:0]  win_in,
	input  pat_ent_t           pat_in,
	output logic [GRP_NUM-1:0] all_s2,
	output logic [GRP_NUM-1:0] any_s2
);
	logic [BYTE_W-1:0]      win_o [PATTERN_MAX];
	pat_ent_t               pat_o [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] match_s1;
	logic [PATTERN_MAX-1:0] anchor_s1;
	logic [PAD_N-1:0]       match_pad;
	logic [PAD_N-1:0]       anchor_pad;

	// Cell 0 holds the newest byte; each cell feeds the next older one
	for (genvar a = 0; a < PATTERN_MAX; a++) begin : g_cell
		if (a == 0) begin : g_head
			mbps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.win_in    (win_in),
				.pat_in    (pat_in),
				.win_out   (win_o[a]),
				.pat_out   (pat_o[a]),
				.match_s1  (match_s1[a]),
				.anchor_s1 (anchor_s1[a])
			);
		end else begin : g_body
			mbps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.win_in    (win_o[a-1]),
				.pat_in    (pat_o[a-1]),
				.win_out   (win_o[a]),
				.pat_out   (pat_o[a]),
				.match_s1  (match_s1[a]),
				.anchor_s1 (anchor_s1[a])
			);
		end
	end

	// Pad the last group with neutral values
	always_comb begin
		match_pad                   = '1;
		anchor_pad                  = '0;
		match_pad[PATTERN_MAX-1:0]  = match_s1;
		anchor_pad[PATTERN_MAX-1:0] = anchor_s1;
	end

	// Fold each group of cells
	always_ff @(posedge clk) begin
		for (int g = 0; g < GRP_NUM; g++) begin
			all_s2[g] <= &match_pad[g*GRP_SIZE +: GRP_SIZE];
			any_s2[g] <= |anchor_pad[g*GRP_SIZE +: GRP_SIZE];
		end
	end
endmodule

// ----- hdl/mbps_regs.sv -----
// APB-style configuration registers of the scanner: length, step, limit, base.
// Depends on mbps_pkg.
module mbps_regs import mbps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg,
	output logic              len_wr
);
	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);
	assign len_wr = wr && (idx == REG_LEN);
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.len   <= LEN_RST;
			cfg_q.step  <= STEP_RST;
			cfg_q.limit <= LIMIT_RST;
			cfg_q.base  <= BASE_RST;
		end else if (wr) begin
			case (idx)
				REG_LEN:   cfg_q.len   <= pwdata[LEN_CFG_W-1:0];
				REG_STEP:  cfg_q.step  <= pwdata[STEP_W-1:0];
				REG_LIMIT: cfg_q.limit <= pwdata[CNT_W-1:0];
				REG_BASE:  cfg_q.base  <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_LEN:   prdata = APB_DW'(cfg_q.len);
			REG_STEP:  prdata = APB_DW'(cfg_q.step);
			REG_LIMIT: prdata = APB_DW'(cfg_q.limit);
			REG_BASE:  prdata = APB_DW'(cfg_q.base);
			default:   prdata = '0;
		endcase
	end
endmodule

// ----- hdl/masked_byte_pattern_scanner.sv -----
// Masked byte pattern scanner: request channel, hit channel, APB config port.
// Depends on mbps_pkg, mbps_req_if, mbps_hit_if, mbps_ram, mbps_row, mbps_regs.
//
// Usage:
//  - req carries one request per handshake: clear (restart scan, drop the
//    pattern's care bits), load (one pattern position) or scan (one data byte).
//  - hit carries one report per matching start: base address plus offset,
//    hit ordinal and a flag on the hit that reaches the hit limit.
//  - Clear and load requests are taken in the idle state and may follow back to back.
//  - A scan request passes the compare, reduce and decide states: the byte shifts
//    into the cell row, the cells compare, the groups fold, then the start is decided. A hit shows
//    on hit.valid in the cycle after the decision.
//  - The first scan request after a load or a pattern_length write waits for
//    a realign pass, which streams the pattern from its RAM into the cell row
//    in age order and then returns to idle; ready stays low meanwhile.
//  - One output register holds a hit; further requests are taken while it
//    waits. A stalled receiver holds the next scan request in the decide step.
//  - Reset clears the window, care bits and counters and sets the config
//    registers to their reset values; the block leaves reset idle and ready.
module masked_byte_pattern_scanner import mbps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mbps_req_if.sink          req,
	mbps_hit_if.source        hit,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	cfg_t                   cfg;
	logic                   len_wr;
	state_t                 state_q;
	state_t                 state_d;
	logic                   accept;
	logic                   acc_scan;
	logic                   acc_load;
	logic                   acc_clear;
	logic                   idx_ok;
	logic                   rb_start;
	logic                   dirty_q;
	logic [LEN_W-1:0]       len_eff;
	logic [STEP_W-1:0]      step_eff;
	logic [LEN_W-1:0]       rb_cnt_q;
	logic [LEN_W:0]         rb_sum;
	logic                   feed;
	logic                   issue;
	logic [PAT_AW-1:0]      rd_addr;
	logic                   feed_s1;
	logic                   feed_care_s1;
	logic                   seen_q;
	logic [BYTE_W-1:0]      ram_rdata;
	logic [PATTERN_MAX-1:0] care_q;
	cell_ctl_t              ctl;
	pat_ent_t               pat_in;
	logic [GRP_NUM-1:0]     all_s2;
	logic [GRP_NUM-1:0]     any_s2;
	logic [ADDR_W-1:0]      off_q;
	logic [ADDR_W-1:0]      t_q;
	logic [ADDR_W-1:0]      lm1;
	logic [ADDR_W-1:0]      start_q;
	logic [ADDR_W-1:0]      nas_q;
	logic [ADDR_W-1:0]      cand_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   early_q;
	logic                   ge_q;
	logic [CNT_W-1:0]       hit_cnt_q;
	logic [CNT_W-1:0]       hit_next;
	logic                   out_free;
	logic                   commit;
	logic                   examine;
	logic                   is_hit;
	logic                   out_valid_q;
	logic [ADDR_W-1:0]      out_addr_q;
	logic [CNT_W-1:0]       out_num_q;
	logic                   out_lim_q;

	mbps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.len_wr  (len_wr)
	);

	// Saturate length, treat a zero step as one
	always_comb begin
		if (32'(cfg.len) > PATTERN_MAX) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end else begin
			len_eff = LEN_W'(cfg.len);
		end
		step_eff = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
	end

	assign accept    = req.valid && req.ready;
	assign acc_scan  = accept && (req.action == ACT_SCAN);
	assign acc_load  = accept && (req.action == ACT_LOAD);
	assign acc_clear = accept && (req.action == ACT_CLEAR);
	assign idx_ok    = 32'(req.entry_index) < PATTERN_MAX;

	// Decide step gating
	assign out_free = !out_valid_q || hit.ready;
	assign commit   = (state_q == ST_DEC) && out_free;
	assign examine  = early_q && ge_q && (|any_s2) && (hit_cnt_q < cfg.limit);
	assign is_hit   = examine && (&all_s2);
	assign hit_next = hit_cnt_q + CNT_W'(1);

	// Next state and request ready
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = !(dirty_q && (req.action == ACT_SCAN));
				if (req.valid && (req.action == ACT_SCAN)) begin
					state_d = dirty_q ? ST_REBUILD : ST_CMP;
				end
			end
			ST_REBUILD: begin
				if (rb_cnt_q == LEN_W'(PATTERN_MAX)) begin
					state_d = ST_IDLE;
				end
			end
			ST_CMP: state_d = ST_RED;
			ST_RED: state_d = ST_DEC;
			ST_DEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign rb_start = (state_q == ST_IDLE) && (state_d == ST_REBUILD);

	// Realign pass: read positions in order, wildcards first for short patterns
	assign issue   = (state_q == ST_REBUILD) && (rb_cnt_q < LEN_W'(PATTERN_MAX));
	assign rb_sum  = (LEN_W+1)'(rb_cnt_q[PAT_AW-1:0]) + (LEN_W+1)'(len_eff);
	assign feed    = rb_sum >= (LEN_W+1)'(PATTERN_MAX);
	assign rd_addr = PAT_AW'(rb_sum - (LEN_W+1)'(PATTERN_MAX));

	// Pattern dirty flag and realign sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q      <= 1'b0;
			rb_cnt_q     <= '0;
			feed_s1      <= 1'b0;
			feed_care_s1 <= 1'b0;
			seen_q       <= 1'b0;
		end else begin
			if (len_wr || acc_load) begin
				dirty_q <= 1'b1;
			end else if (rb_start) begin
				dirty_q <= 1'b0;
			end
			if (rb_start) begin
				rb_cnt_q <= '0;
			end else if (state_q == ST_REBUILD) begin
				rb_cnt_q <= rb_cnt_q + LEN_W'(1);
			end
			feed_s1      <= issue;
			feed_care_s1 <= issue && feed && care_q[rd_addr];
			if (rb_start) begin
				seen_q <= 1'b0;
			end else if (feed_s1 && feed_care_s1) begin
				seen_q <= 1'b1;
			end
		end
	end

	// Care bits in pattern order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			care_q <= '0;
		end else if (acc_clear) begin
			care_q <= '0;
		end else if (acc_load && idx_ok) begin
			care_q[PAT_AW'(req.entry_index)] <= req.entry_cares;
		end
	end

	mbps_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PATTERN_MAX)
	) u_pat_ram (
		.clk   (clk),
		.we    (acc_load && idx_ok),
		.waddr (PAT_AW'(req.entry_index)),
		.wdata (req.entry_byte),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Cell row
	assign ctl.win_shift = acc_scan;
	assign ctl.pat_shift = feed_s1;
	assign ctl.clear     = acc_clear;
	assign pat_in.val    = ram_rdata;
	assign pat_in.care   = feed_care_s1;
	assign pat_in.anchor = feed_care_s1 && !seen_q;

	mbps_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.win_in (req.data_byte),
		.pat_in (pat_in),
		.all_s2 (all_s2),
		.any_s2 (any_s2)
	);

	// Scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			nas_q     <= '0;
			hit_cnt_q <= '0;
		end else if (acc_clear) begin
			off_q     <= '0;
			nas_q     <= '0;
			hit_cnt_q <= '0;
		end else begin
			if (acc_scan) begin
				off_q <= off_q + ADDR_W'(1);
			end
			if (commit && examine) begin
				nas_q <= cand_q;
			end
			if (commit && is_hit) begin
				hit_cnt_q <= hit_next;
			end
		end
	end

	assign lm1 = ADDR_W'(len_eff) - ADDR_W'(1);

	// Start offset arithmetic, spread over the accept, compare and reduce steps
	always_ff @(posedge clk) begin
		if (acc_scan) begin
			t_q <= off_q;
		end
		if (state_q == ST_CMP) begin
			start_q <= t_q - lm1;
			early_q <= (len_eff != '0) && (t_q >= lm1);
		end
		if (state_q == ST_RED) begin
			ge_q   <= start_q >= nas_q;
			addr_q <= cfg.base + start_q;
			cand_q <= start_q + ADDR_W'(step_eff);
		end
	end

	// Hit output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && is_hit) begin
			out_valid_q <= 1'b1;
		end else if (hit.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && is_hit) begin
			out_addr_q <= addr_q;
			out_num_q  <= hit_next;
			out_lim_q  <= hit_next == cfg.limit;
		end
	end

	assign hit.valid         = out_valid_q;
	assign hit.hit_address   = out_addr_q;
	assign hit.hit_number    = out_num_q;
	assign hit.limit_reached = out_lim_q;
endmodule
